// ===== rtl/core/single_wire_sensor_reader_unit_assert.svh =====
// assertion macros for the single-wire sensor reader
// expects clk and rst in the scope of each use
`ifndef SINGLE_WIRE_SENSOR_READER_UNIT_ASSERT_SVH
`define SINGLE_WIRE_SENSOR_READER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SWSR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SWSR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWSR_ASSERT(name, prop, msg)
`define SWSR_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== rtl/core/swsr_pkg.sv =====
// shared types and constants of the single-wire sensor reader
// no dependencies
package swsr_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_REQUEST_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_TICKS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BYTES   = 2'd2;

  localparam logic [15:0] REQUEST_TICKS_RST = 16'd18420;
  localparam logic [15:0] SAMPLE_TICKS_RST  = 16'd15;
  localparam logic [3:0]  FRAME_BYTES_RST   = 4'd5;
  localparam logic [3:0]  FRAME_BYTES_MAX   = 4'd8;

  typedef struct packed {
    logic [15:0] request_ticks;
    logic [15:0] sample_ticks;
    logic [3:0]  frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       busy_res;
  } res_t;

endpackage

// ===== rtl/core/swsr_if.sv =====
// valid/ready channels of the single-wire sensor reader
// no dependencies
interface swsr_tick_if;
  logic valid;
  logic ready;
  logic line_level;
  logic start_req;

  modport source (output valid, output line_level, output start_req, input ready);
  modport sink (input valid, input line_level, input start_req, output ready);
endinterface

interface swsr_result_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       byte_valid;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       busy_res;

  modport source (output valid, output drive_low, output byte_valid, output data_byte,
                  output last_byte, output busy_res, input ready);
  modport sink (input valid, input drive_low, input byte_valid, input data_byte,
                input last_byte, input busy_res, output ready);
endinterface

// ===== rtl/core/swsr_cfg_regs.sv =====
// configuration registers of the single-wire sensor reader
// depends on swsr_pkg
module swsr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [swsr_pkg::CFG_INDEX_W-1:0]    index,
  input  logic [swsr_pkg::CFG_DATA_W-1:0]     data,
  output swsr_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.request_ticks <= swsr_pkg::REQUEST_TICKS_RST;
      cfg.sample_ticks  <= swsr_pkg::SAMPLE_TICKS_RST;
      cfg.frame_bytes   <= swsr_pkg::FRAME_BYTES_RST;
    end else if (wr_en) begin
      unique case (index)
        swsr_pkg::CFG_REQUEST_TICKS: cfg.request_ticks <= data;
        swsr_pkg::CFG_SAMPLE_TICKS:  cfg.sample_ticks  <= data;
        swsr_pkg::CFG_FRAME_BYTES:   cfg.frame_bytes   <= data[3:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/swsr_core.sv =====
// transaction sequencer: one timer tick per step, one result per tick
// depends on swsr_pkg and single_wire_sensor_reader_unit_assert.svh
`include "single_wire_sensor_reader_unit_assert.svh"

module swsr_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           step_en,
  input  logic           line_level,
  input  logic           start_req,
  input  swsr_pkg::cfg_t cfg,
  output swsr_pkg::res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_REQ, PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_END, PH_BIT_HIGH, PH_BIT_DELAY,
    PH_BIT_LOW
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next, tick_inc;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next, shifted;
  logic [2:0]  byte_index, byte_index_next;
  logic [15:0] req_lim, smp_lim;
  logic [3:0]  frame_len;

  assign req_lim  = (cfg.request_ticks == 16'd0) ? 16'd1 : cfg.request_ticks;
  assign smp_lim  = (cfg.sample_ticks == 16'd0) ? 16'd1 : cfg.sample_ticks;
  assign tick_inc = tick_count + 16'd1;
  assign shifted  = {shift_byte[6:0], line_level};

  always_comb begin
    if (cfg.frame_bytes == 4'd0) begin
      frame_len = 4'd1;
    end else if (cfg.frame_bytes > swsr_pkg::FRAME_BYTES_MAX) begin
      frame_len = swsr_pkg::FRAME_BYTES_MAX;
    end else begin
      frame_len = cfg.frame_bytes;
    end
  end

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    byte_index_next = byte_index;
    res             = '0;
    res.busy_res    = (phase != PH_IDLE);
    unique case (phase)
      PH_IDLE: begin
        if (start_req) begin
          res.busy_res    = 1'b1;
          res.drive_low   = 1'b1;
          tick_count_next = 16'd1;
          bit_index_next  = '0;
          byte_index_next = '0;
          shift_byte_next = '0;
          phase_next      = (req_lim == 16'd1) ? PH_ACK_LOW : PH_REQ;
        end
      end
      PH_REQ: begin
        res.drive_low   = 1'b1;
        tick_count_next = tick_inc;
        if (tick_inc >= req_lim) phase_next = PH_ACK_LOW;
      end
      PH_ACK_LOW: begin
        if (!line_level) phase_next = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        if (line_level) phase_next = PH_ACK_END;
      end
      PH_ACK_END: begin
        if (!line_level) phase_next = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        if (line_level) begin
          tick_count_next = '0;
          phase_next      = PH_BIT_DELAY;
        end
      end
      PH_BIT_DELAY: begin
        tick_count_next = tick_inc;
        if (tick_inc >= smp_lim) begin
          shift_byte_next = shifted;
          bit_index_next  = bit_index + 3'd1;
          phase_next      = PH_BIT_LOW;
          if (bit_index == 3'(swsr_pkg::BITS_PER_BYTE - 1)) begin
            res.byte_valid = 1'b1;
            res.data_byte  = shifted;
            if ({1'b0, byte_index} + 4'd1 >= frame_len) begin
              res.last_byte   = 1'b1;
              byte_index_next = '0;
              phase_next      = PH_IDLE;
            end else begin
              byte_index_next = byte_index + 3'd1;
            end
          end
        end
      end
      PH_BIT_LOW: begin
        if (!line_level) phase_next = PH_BIT_HIGH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      byte_index <= '0;
    end else if (step_en) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      byte_index <= byte_index_next;
    end
  end

  `SWSR_ASSERT(a_byte_while_busy, res.byte_valid |-> res.busy_res, "byte outside transaction")
  `SWSR_ASSERT(a_last_is_byte, res.last_byte |-> res.byte_valid, "last flag without byte")
  `SWSR_ASSERT_NEXT(a_last_to_idle, step_en && res.last_byte, phase == PH_IDLE, "no idle after frame")
  `SWSR_ASSERT_NEXT(a_hold_on_stall, !step_en, $stable(phase) && $stable(shift_byte), "state moved without step")

endmodule

// ===== rtl/core/single_wire_sensor_reader_unit.sv =====
// top level of the single-wire sensor reader
// depends on swsr_pkg, swsr_if, swsr_cfg_regs and swsr_core
//
// tick channel: one transfer per timer tick, carrying the sampled data-line
// level and a start flag. result channel: exactly one transfer per tick,
// carrying the line drive, an optional received byte with its last flag and
// the busy flag.
// configuration: cfg_wr_en, cfg_index and cfg_data write request_ticks (0),
// sample_ticks (1) and frame_bytes (2); other indexes are ignored.
// write only while no tick is in flight.
// path: a transferred tick is registered in the input register; its result
// is registered in the output register once that register is free, and is
// offered on the result channel from there.
// throughput: one tick per cycle while the receiver takes results; the
// sequencer state updates from the input register.
// reset: sequencer idle, both registers empty, configuration back to
// 18420, 15 and 5.
// receiver stall: the output register holds its result and the input
// register holds one further tick; tick.ready falls once both are full.
module single_wire_sensor_reader_unit (
  input  logic                              clk,
  input  logic                              rst,
  swsr_tick_if.sink                         tick,
  swsr_result_if.source                     result,
  input  logic                              cfg_wr_en,
  input  logic [swsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [swsr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  swsr_pkg::cfg_t cfg;
  swsr_pkg::res_t res;
  swsr_pkg::res_t res_q;
  logic           in_valid;
  logic           line_q;
  logic           start_q;
  logic           out_valid;
  logic           advance;

  swsr_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  swsr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step_en    (advance),
    .line_level (line_q),
    .start_req  (start_q),
    .cfg        (cfg),
    .res        (res)
  );

  assign advance    = in_valid && (!out_valid || result.ready);
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (tick.ready) in_valid <= tick.valid;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      line_q  <= tick.line_level;
      start_q <= tick.start_req;
    end
    if (advance) res_q <= res;
  end

  assign result.valid      = out_valid;
  assign result.drive_low  = res_q.drive_low;
  assign result.byte_valid = res_q.byte_valid;
  assign result.data_byte  = res_q.data_byte;
  assign result.last_byte  = res_q.last_byte;
  assign result.busy_res   = res_q.busy_res;

endmodule

// ===== bench/swsr_frame_check.sv =====
// scoreboard for the single-wire sensor reader: predicts one result per tick transfer
// depends on swsr_pkg and the tick/result channel interfaces in swsr_if
module swsr_frame_check import swsr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  swsr_tick_if                   tick,
  swsr_result_if                 result,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fails,
  output int                     pending,
  output logic                   seq_idle,
  output int                     bytes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    S_IDLE, S_REQ, S_ACK_LOW, S_ACK_HIGH, S_ACK_END, S_BIT_HIGH, S_BIT_DELAY, S_BIT_LOW
  } seq_phase_t;

  cfg_t        regs;
  seq_phase_t  phase;
  logic [15:0] tick_cnt;
  logic [2:0]  bit_idx;
  logic [7:0]  shreg;
  logic [2:0]  byte_idx;
  res_t        due_results[$];
  int          results_seen;

  assign seq_idle = (phase == S_IDLE);

  function automatic res_t next_tick_result(input logic lvl, input logic st);
    res_t        r;
    logic [15:0] req_min;
    logic [15:0] smp_min;
    logic [3:0]  flen;
    r = '0;
    r.busy_res = (phase != S_IDLE);
    req_min = (regs.request_ticks == 16'd0) ? 16'd1 : regs.request_ticks;
    smp_min = (regs.sample_ticks == 16'd0) ? 16'd1 : regs.sample_ticks;
    if (regs.frame_bytes == 4'd0) flen = 4'd1;
    else if (regs.frame_bytes > FRAME_BYTES_MAX) flen = FRAME_BYTES_MAX;
    else flen = regs.frame_bytes;
    case (phase)
      S_IDLE: begin
        if (st) begin
          r.busy_res = 1'b1;
          r.drive_low = 1'b1;
          tick_cnt = 16'd1;
          bit_idx = '0;
          byte_idx = '0;
          shreg = '0;
          phase = (tick_cnt >= req_min) ? S_ACK_LOW : S_REQ;
        end
      end
      S_REQ: begin
        r.drive_low = 1'b1;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= req_min) phase = S_ACK_LOW;
      end
      S_ACK_LOW: if (!lvl) phase = S_ACK_HIGH;
      S_ACK_HIGH: if (lvl) phase = S_ACK_END;
      S_ACK_END: if (!lvl) phase = S_BIT_HIGH;
      S_BIT_HIGH: begin
        if (lvl) begin
          tick_cnt = '0;
          phase = S_BIT_DELAY;
        end
      end
      S_BIT_DELAY: begin
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= smp_min) begin
          shreg = {shreg[6:0], lvl};
          bit_idx = bit_idx + 3'd1;
          phase = S_BIT_LOW;
          // bit counter wraps once eight bits are in
          if (bit_idx == 3'd0) begin
            r.byte_valid = 1'b1;
            r.data_byte = shreg;
            if (4'(byte_idx) + 4'd1 >= flen) begin
              r.last_byte = 1'b1;
              byte_idx = '0;
              phase = S_IDLE;
            end else begin
              byte_idx = byte_idx + 3'd1;
            end
          end
        end
      end
      default: if (!lvl) phase = S_BIT_HIGH;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (rst) begin
      regs = '{request_ticks: REQUEST_TICKS_RST, sample_ticks: SAMPLE_TICKS_RST,
               frame_bytes: FRAME_BYTES_RST};
      phase = S_IDLE;
      tick_cnt = '0;
      bit_idx = '0;
      shreg = '0;
      byte_idx = '0;
      due_results.delete();
      fails = 0;
      bytes_checked = 0;
      results_seen = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_REQUEST_TICKS: regs.request_ticks = cfg_data;
          CFG_SAMPLE_TICKS:  regs.sample_ticks = cfg_data;
          CFG_FRAME_BYTES:   regs.frame_bytes = cfg_data[3:0];
          default: ;
        endcase
      end
      if (tick.valid && tick.ready)
        due_results.push_back(next_tick_result(tick.line_level, tick.start_req));
      if (result.valid && result.ready) begin
        got.drive_low = result.drive_low;
        got.byte_valid = result.byte_valid;
        got.data_byte = result.data_byte;
        got.last_byte = result.last_byte;
        got.busy_res = result.busy_res;
        if (got.byte_valid) bytes_checked++;
        if (due_results.size() == 0) begin
          if (fails < 10)
            $display("result %0d arrived with nothing expected", results_seen);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (got.drive_low !== want.drive_low || got.byte_valid !== want.byte_valid ||
              got.data_byte !== want.data_byte || got.last_byte !== want.last_byte ||
              got.busy_res !== want.busy_res) begin
            if (fails < 10) begin
              $display("result %0d: exp drive %0b valid %0b byte %02h last %0b busy %0b",
                       results_seen, want.drive_low, want.byte_valid, want.data_byte,
                       want.last_byte, want.busy_res);
              $display("result %0d: got drive %0b valid %0b byte %02h last %0b busy %0b",
                       results_seen, got.drive_low, got.byte_valid, got.data_byte,
                       got.last_byte, got.busy_res);
            end
            fails++;
          end
        end
        results_seen++;
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== bench/tb_single_wire_sensor_reader_unit.sv =====
// testbench top for single_wire_sensor_reader_unit: drives sensor-like tick streams
// depends on swsr_pkg, swsr_if, the unit itself and swsr_frame_check
module tb_single_wire_sensor_reader_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import swsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_TICKS   = 400;
  localparam int RANDOM_BYTES   = 16;
  localparam int TAIL_CYCLES    = 8;
  localparam int RESET_PEEK     = 40;
  localparam int WIDE_PEEK      = 260;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int   fails;
  int   pending;
  int   bytes_checked;
  logic seq_idle;
  bit   calm;
  int   quiet_cycles;
  int   ticks_sent;
  int   frames_sent;
  int   settings_used;

  logic [15:0] req_eff;
  logic [15:0] smp_eff;
  int          frame_len;

  swsr_tick_if   tick_ch();
  swsr_result_if res_ch();

  single_wire_sensor_reader_unit uut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch.sink),
    .result    (res_ch.source),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  swsr_frame_check scoreboard (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick_ch),
    .result        (res_ch),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fails         (fails),
    .pending       (pending),
    .seq_idle      (seq_idle),
    .bytes_checked (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    res_ch.ready <= calm || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("single_wire_sensor_reader_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic stray_start();
    return ($urandom_range(3) == 0);
  endfunction

  function automatic logic rand_level();
    return 1'($urandom_range(1));
  endfunction

  task automatic send_tick(input logic lvl, input logic st);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 16) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.line_level <= lvl;
    tick_ch.start_req <= st;
    do @(posedge clk); while (!tick_ch.ready);
    ticks_sent++;
  endtask

  task automatic hold_sender();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    hold_sender();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] req, input logic [15:0] smp,
                           input logic [3:0] fb);
    drain();
    write_reg(CFG_REQUEST_TICKS, req);
    write_reg(CFG_SAMPLE_TICKS, smp);
    write_reg(CFG_FRAME_BYTES, {12'($urandom), fb});
    req_eff = (req == 16'd0) ? 16'd1 : req;
    smp_eff = (smp == 16'd0) ? 16'd1 : smp;
    frame_len = (fb == 4'd0) ? 1 : ((fb > FRAME_BYTES_MAX) ? 8 : int'(fb));
    settings_used++;
  endtask

  // walk the sequencer back to idle with plain bit shapes
  task automatic settle();
    hold_sender();
    while (!seq_idle) begin
      send_tick(1'b0, 1'b0);
      repeat (smp_eff + 1) send_tick(1'b1, 1'b0);
      hold_sender();
    end
  endtask

  task automatic send_bit(input logic val, input bit mangle);
    int i;
    int n;
    if (mangle) begin
      n = $urandom_range(smp_eff + 3, 1);
      for (i = 0; i < n; i++) send_tick(rand_level(), stray_start());
    end else begin
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++) send_tick(1'b0, stray_start());
      send_tick(1'b1, stray_start());
      for (i = 1; i < smp_eff; i++) send_tick(rand_level(), stray_start());
      send_tick(val, stray_start());
      if (val) repeat ($urandom_range(2)) send_tick(1'b1, 1'b0);
    end
  endtask

  task automatic send_ack();
    repeat ($urandom_range(3, 1)) send_tick(1'b0, stray_start());
    repeat ($urandom_range(3, 1)) send_tick(1'b1, stray_start());
  endtask

  task automatic send_frame(input logic [63:0] content, input int mangle_pct);
    int i;
    send_tick(rand_level(), 1'b1);
    for (i = 1; i < req_eff; i++) send_tick(rand_level(), stray_start());
    send_ack();
    for (i = 0; i < 8 * frame_len; i++)
      send_bit(content[63 - i], $urandom_range(99) < mangle_pct);
    frames_sent++;
    settle();
  endtask

  // hold the request for a while, then shorten it so the answer follows
  task automatic cut_request(input int peek);
    send_tick(rand_level(), 1'b1);
    repeat (peek) send_tick(rand_level(), stray_start());
    drain();
    write_reg(CFG_REQUEST_TICKS, 16'd1);
    req_eff = 16'd1;
    send_tick(rand_level(), stray_start());
    send_ack();
  endtask

  task automatic line_noise();
    repeat ($urandom_range(40, 5)) send_tick(rand_level(), $urandom_range(7) == 0);
    settle();
  endtask

  initial begin
    int act;
    int i;
    int rnd_ticks0;
    int rnd_bytes0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_REQUEST_TICKS;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.line_level = 1'b1;
    tick_ch.start_req = 1'b0;
    res_ch.ready = 1'b0;
    calm = 1'b0;
    req_eff = REQUEST_TICKS_RST;
    smp_eff = SAMPLE_TICKS_RST;
    frame_len = int'(FRAME_BYTES_RST);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register values out of reset: long request, first byte at the reset sample delay
    cut_request(RESET_PEEK);
    for (i = 0; i < 8; i++) send_bit(rand_level(), 1'b0);
    drain();
    write_reg(CFG_SAMPLE_TICKS, 16'd1);
    smp_eff = 16'd1;
    for (i = 8; i < 8 * frame_len; i++) send_bit(rand_level(), 1'b0);
    frames_sent++;
    settle();

    // shortest timing, all-ones then all-zeros byte
    configure(16'd1, 16'd1, 4'd2);
    write_reg(CFG_SPARE, 16'($urandom));
    send_frame({8'hFF, 8'h00, 48'h0}, 0);
    // zero registers behave as one
    configure(16'd0, 16'd0, 4'd0);
    send_frame({$urandom, $urandom}, 0);
    configure(16'd1, 16'd1, 4'd15);
    send_frame({$urandom, $urandom}, 0);
    line_noise();

    rnd_ticks0 = ticks_sent;
    rnd_bytes0 = bytes_checked;
    while (ticks_sent - rnd_ticks0 < RANDOM_TICKS ||
           bytes_checked - rnd_bytes0 < RANDOM_BYTES) begin
      configure(16'($urandom_range(12)), 16'($urandom_range(4)), 4'($urandom_range(15)));
      repeat ($urandom_range(3, 1)) begin
        act = $urandom_range(99);
        if (act < 70) send_frame({$urandom, $urandom}, 0);
        else if (act < 85) send_frame({$urandom, $urandom}, 20);
        else line_noise();
      end
    end

    // widest tick registers, one byte, counts run well past eight bits
    calm = 1'b1;
    configure(16'hFFFF, 16'hFFFF, 4'd1);
    cut_request(WIDE_PEEK);
    send_tick(1'b0, stray_start());
    send_tick(1'b1, stray_start());
    repeat (WIDE_PEEK) send_tick(rand_level(), stray_start());
    drain();
    write_reg(CFG_SAMPLE_TICKS, 16'd1);
    smp_eff = 16'd1;
    send_tick(rand_level(), stray_start());
    for (i = 1; i < 8; i++) send_bit(rand_level(), 1'b0);
    frames_sent++;
    settle();
    calm = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d ticks in %0d frames across %0d register settings",
             ticks_sent, frames_sent, settings_used);
    $display("%0d bytes received and compared, %0d mismatches, %0d results left over",
             bytes_checked, fails, pending);
    if (fails == 0 && pending == 0) begin
      $display("single_wire_sensor_reader_unit test passed");
    end else begin
      $display("single_wire_sensor_reader_unit test failed");
    end
    $finish;
  end

endmodule
